// ===== rtl/core/mpbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mpbf_pkg;

	localparam int NUM_PIPES  = 64;
	localparam int RING_DEPTH = 512;

	localparam int PIPE_W    = $clog2(NUM_PIPES);
	localparam int SLOT_W    = $clog2(RING_DEPTH);
	localparam int CNT_W     = SLOT_W + 1;
	localparam int RING_AW   = PIPE_W + SLOT_W;
	localparam int RING_WORDS = NUM_PIPES * RING_DEPTH;

	localparam int GRP_SIZE = 8;
	localparam int GRP_IW   = $clog2(GRP_SIZE);
	localparam int NUM_GRPS = NUM_PIPES / GRP_SIZE;
	localparam int GRP_W    = $clog2(NUM_GRPS);

	localparam int OP_W   = 3;
	localparam int IDX_W  = 6;
	localparam int BYTE_W = 8;
	localparam int ST_W   = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 3'd0,
		OP_WRITE    = 3'd1,
		OP_READ     = 3'd2,
		OP_CLOSE_RD = 3'd3,
		OP_CLOSE_WR = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK         = 3'd0,
		ST_FULL_WAIT  = 3'd1,
		ST_EMPTY_WAIT = 3'd2,
		ST_SHORT      = 3'd3,
		ST_EOS        = 3'd4,
		ST_BROKEN     = 3'd5,
		ST_NO_FREE    = 3'd6,
		ST_NOT_ALLOC  = 3'd7
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0] rd;
		logic [CNT_W-1:0] wr;
	} cnt_pair_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic              set_en;
		logic              clr_en;
		logic [PIPE_W-1:0] idx;
	} alloc_req_t;

	typedef struct packed {
		logic              busy;
		logic              any_free;
		logic [PIPE_W-1:0] free_idx;
	} alloc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mpbf_alloc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpbf_alloc (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mpbf_pkg::alloc_req_t        req,
	input  wire logic [mpbf_pkg::PIPE_W-1:0] query_idx,
	output mpbf_pkg::alloc_sts_t             sts
);

	logic [mpbf_pkg::NUM_PIPES-1:0] map_q;
	logic [mpbf_pkg::NUM_PIPES-1:0] free_bits;
	logic [mpbf_pkg::NUM_GRPS-1:0]  grp_any_c;
	logic [mpbf_pkg::GRP_IW-1:0]    grp_idx_c [mpbf_pkg::NUM_GRPS];
	logic [mpbf_pkg::NUM_GRPS-1:0]  grp_any_s1;
	logic [mpbf_pkg::GRP_IW-1:0]    grp_idx_s1 [mpbf_pkg::NUM_GRPS];
	logic                           any_c;
	logic [mpbf_pkg::PIPE_W-1:0]    idx_c;
	logic                           any_s2;
	logic [mpbf_pkg::PIPE_W-1:0]    idx_s2;

	assign free_bits = ~map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else if (req.set_en) begin
			map_q[req.idx] <= 1'b1;
		end else if (req.clr_en) begin
			map_q[req.idx] <= 1'b0;
		end
	end

	// first stage: lowest free pipe inside each group
	always_comb begin
		for (int g = 0; g < mpbf_pkg::NUM_GRPS; g++) begin
			grp_any_c[g] = |free_bits[g*mpbf_pkg::GRP_SIZE +: mpbf_pkg::GRP_SIZE];
			grp_idx_c[g] = '0;
			for (int b = mpbf_pkg::GRP_SIZE - 1; b >= 0; b--) begin
				if (free_bits[g*mpbf_pkg::GRP_SIZE + b]) begin
					grp_idx_c[g] = mpbf_pkg::GRP_IW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_any_s1 <= '1;
			for (int g = 0; g < mpbf_pkg::NUM_GRPS; g++) begin
				grp_idx_s1[g] <= '0;
			end
		end else begin
			grp_any_s1 <= grp_any_c;
			for (int g = 0; g < mpbf_pkg::NUM_GRPS; g++) begin
				grp_idx_s1[g] <= grp_idx_c[g];
			end
		end
	end

	// second stage: lowest group holding a free pipe
	always_comb begin
		any_c = |grp_any_s1;
		idx_c = '0;
		for (int g = mpbf_pkg::NUM_GRPS - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				idx_c = {mpbf_pkg::GRP_W'(g), grp_idx_s1[g]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s2 <= 1'b1;
			idx_s2 <= '0;
		end else begin
			any_s2 <= any_c;
			idx_s2 <= idx_c;
		end
	end

	assign sts.busy     = map_q[query_idx];
	assign sts.any_free = any_s2;
	assign sts.free_idx = idx_s2;

endmodule

`default_nettype wire

// ===== rtl/core/mpbf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpbf_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mpbf_pkg::ctl_cmd_t          cmd,
	input  wire logic [mpbf_pkg::OP_W-1:0]   operation,
	input  wire logic [mpbf_pkg::IDX_W-1:0]  pipe_index,
	input  wire logic [mpbf_pkg::BYTE_W-1:0] data_in,
	input  wire logic                        first_in_request,
	output logic [mpbf_pkg::ST_W-1:0]        status,
	output logic [mpbf_pkg::IDX_W-1:0]       allocated_index,
	output logic [mpbf_pkg::BYTE_W-1:0]      data_out
);

	mpbf_pkg::op_t                 op_q;
	logic [mpbf_pkg::PIPE_W-1:0]   pipe_q;
	logic [mpbf_pkg::BYTE_W-1:0]   byte_q;
	logic                          first_q;
	mpbf_pkg::cnt_pair_t           cnt_q;
	mpbf_pkg::cnt_pair_t           cnt_mem [mpbf_pkg::NUM_PIPES];
	logic [mpbf_pkg::BYTE_W-1:0]   ring_mem [mpbf_pkg::RING_WORDS];
	logic [mpbf_pkg::BYTE_W-1:0]   ring_q;
	logic [mpbf_pkg::NUM_PIPES-1:0] rd_open_q;
	logic [mpbf_pkg::NUM_PIPES-1:0] wr_open_q;
	mpbf_pkg::status_t             st_q;
	logic [mpbf_pkg::IDX_W-1:0]    aidx_q;
	logic                          rd_ok_q;
	logic [mpbf_pkg::ST_W-1:0]     status_q;
	logic [mpbf_pkg::IDX_W-1:0]    alloc_out_q;
	logic [mpbf_pkg::BYTE_W-1:0]   data_out_q;

	mpbf_pkg::alloc_req_t          areq;
	mpbf_pkg::alloc_sts_t          asts;

	mpbf_pkg::status_t             st_c;
	logic [mpbf_pkg::IDX_W-1:0]    aidx_c;
	logic                          rd_ok_c;
	logic                          cnt_we;
	logic [mpbf_pkg::PIPE_W-1:0]   cnt_waddr;
	mpbf_pkg::cnt_pair_t           cnt_wdata;
	logic                          ring_we;
	logic [mpbf_pkg::RING_AW-1:0]  ring_waddr;
	logic [mpbf_pkg::RING_AW-1:0]  ring_raddr;
	logic [mpbf_pkg::NUM_PIPES-1:0] rd_open_c;
	logic [mpbf_pkg::NUM_PIPES-1:0] wr_open_c;
	logic [mpbf_pkg::CNT_W-1:0]    fill;

	mpbf_alloc u_alloc (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (areq),
		.query_idx (pipe_q),
		.sts       (asts)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= mpbf_pkg::op_t'(operation);
			pipe_q  <= mpbf_pkg::PIPE_W'(pipe_index);
			byte_q  <= data_in;
			first_q <= first_in_request;
			cnt_q   <= cnt_mem[mpbf_pkg::PIPE_W'(pipe_index)];
		end
	end

	assign fill       = cnt_q.wr - cnt_q.rd;
	assign ring_waddr = {pipe_q, cnt_q.wr[mpbf_pkg::SLOT_W-1:0]};
	assign ring_raddr = {pipe_q, cnt_q.rd[mpbf_pkg::SLOT_W-1:0]};

	always_comb begin
		st_c       = mpbf_pkg::ST_OK;
		aidx_c     = '0;
		rd_ok_c    = 1'b0;
		cnt_we     = 1'b0;
		cnt_waddr  = pipe_q;
		cnt_wdata  = cnt_q;
		ring_we    = 1'b0;
		rd_open_c  = rd_open_q;
		wr_open_c  = wr_open_q;
		areq       = '0;
		areq.idx   = pipe_q;
		unique case (op_q) inside
			mpbf_pkg::OP_ALLOC: begin
				if (asts.any_free) begin
					aidx_c                  = mpbf_pkg::IDX_W'(asts.free_idx);
					cnt_we                  = 1'b1;
					cnt_waddr               = asts.free_idx;
					cnt_wdata               = '0;
					rd_open_c[asts.free_idx] = 1'b1;
					wr_open_c[asts.free_idx] = 1'b1;
					areq.set_en             = 1'b1;
					areq.idx                = asts.free_idx;
				end else begin
					st_c = mpbf_pkg::ST_NO_FREE;
				end
			end
			mpbf_pkg::OP_WRITE, mpbf_pkg::OP_READ,
			mpbf_pkg::OP_CLOSE_RD, mpbf_pkg::OP_CLOSE_WR: begin
				if (!asts.busy) begin
					st_c = mpbf_pkg::ST_NOT_ALLOC;
				end else if (op_q == mpbf_pkg::OP_WRITE) begin
					if (!rd_open_q[pipe_q]) begin
						st_c = mpbf_pkg::ST_BROKEN;
					end else if (fill == mpbf_pkg::CNT_W'(mpbf_pkg::RING_DEPTH)) begin
						st_c = mpbf_pkg::ST_FULL_WAIT;
					end else begin
						ring_we      = 1'b1;
						cnt_we       = 1'b1;
						cnt_wdata.wr = cnt_q.wr + mpbf_pkg::CNT_W'(1);
					end
				end else if (op_q == mpbf_pkg::OP_READ) begin
					if (cnt_q.rd == cnt_q.wr) begin
						if (!wr_open_q[pipe_q]) begin
							st_c = mpbf_pkg::ST_EOS;
						end else if (first_q) begin
							st_c = mpbf_pkg::ST_EMPTY_WAIT;
						end else begin
							st_c = mpbf_pkg::ST_SHORT;
						end
					end else begin
						rd_ok_c      = 1'b1;
						cnt_we       = 1'b1;
						cnt_wdata.rd = cnt_q.rd + mpbf_pkg::CNT_W'(1);
					end
				end else begin
					if (op_q == mpbf_pkg::OP_CLOSE_WR) begin
						wr_open_c[pipe_q] = 1'b0;
					end else begin
						rd_open_c[pipe_q] = 1'b0;
					end
					areq.clr_en = !rd_open_c[pipe_q] && !wr_open_c[pipe_q];
				end
			end
			default: ;
		endcase
		if (!cmd.exec) begin
			areq.set_en = 1'b0;
			areq.clr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_open_q <= '0;
			wr_open_q <= '0;
		end else if (cmd.exec) begin
			rd_open_q <= rd_open_c;
			wr_open_q <= wr_open_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			st_q    <= st_c;
			aidx_q  <= aidx_c;
			rd_ok_q <= rd_ok_c;
			if (cnt_we) begin
				cnt_mem[cnt_waddr] <= cnt_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && ring_we) begin
			ring_mem[ring_waddr] <= byte_q;
		end
		if (cmd.exec) begin
			ring_q <= ring_mem[ring_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q    <= st_q;
			alloc_out_q <= aidx_q;
			data_out_q  <= rd_ok_q ? ring_q : '0;
		end
	end

	assign status          = status_q;
	assign allocated_index = alloc_out_q;
	assign data_out        = data_out_q;

endmodule

`default_nettype wire

// ===== rtl/core/mpbf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpbf_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	output mpbf_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = (state_q == S_IDLE) && in_valid;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.load    = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (cmd.load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_EXEC))
		else $error("capture not followed by execute");

	a_exec_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_FIN))
		else $error("execute not followed by finish");

	a_fin_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not loaded into free output slot");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.capture)
		else $error("item taken while another is in flight");

endmodule

`default_nettype wire

// ===== rtl/core/multi_pipe_byte_fifo_engine.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    operation, pipe_index, data_in, first_in_request
// out      out_valid / out_ready  status, allocated_index, data_out
//
// Each item is accepted with a counter read, executed with counter and ring
// update, then loaded into the output register.
// The free-pipe search is a two-stage pipeline.
// A held output register delays the load only; the next item is taken once loaded.
// arst_n clears pipe flags, the allocation map and all handshake state.
`timescale 1ns / 1ps
`default_nettype none

module multi_pipe_byte_fifo_engine (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mpbf_pkg::OP_W-1:0]   operation,
	input  wire logic [mpbf_pkg::IDX_W-1:0]  pipe_index,
	input  wire logic [mpbf_pkg::BYTE_W-1:0] data_in,
	input  wire logic                        first_in_request,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mpbf_pkg::ST_W-1:0]        status,
	output logic [mpbf_pkg::IDX_W-1:0]       allocated_index,
	output logic [mpbf_pkg::BYTE_W-1:0]      data_out
);

	mpbf_pkg::ctl_cmd_t cmd;

	mpbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mpbf_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.operation        (operation),
		.pipe_index       (pipe_index),
		.data_in          (data_in),
		.first_in_request (first_in_request),
		.status           (status),
		.allocated_index  (allocated_index),
		.data_out         (data_out)
	);

endmodule

`default_nettype wire
